[rtl/armseq_pkg.sv]
// ----------------------------------------------------------------------------
// armseq_pkg
// Shared types, codes and constants of the autoranging R/C meter sequencer.
// ----------------------------------------------------------------------------
package armseq_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int VALUE_W     = 40;
  localparam int HOLD_W      = 16;
  localparam int TICKS_W     = 14;
  localparam int RANGE_W     = 20;
  localparam int FULL_COUNTS = 4020;

  localparam logic [VALUE_W-1:0] MAX_VALUE = {VALUE_W{1'b1}};
  localparam logic [HOLD_W-1:0]  HOLD_MAX  = {HOLD_W{1'b1}};

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] RST_IN_RANGE_LIMIT = 12'd3900;
  localparam logic [SAMPLE_W-1:0] RST_DISCHARGED     = 12'd82;
  localparam logic [SAMPLE_W-1:0] RST_CHARGED        = 12'd2580;
  localparam logic [TICKS_W-1:0]  RST_HOLD_TICKS     = 14'd1000;
  localparam logic [TICKS_W-1:0]  RST_DISCH_TIMEOUT  = 14'd5000;
  localparam logic [TICKS_W-1:0]  RST_CHARGE_LIMIT   = 14'd1000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MEASURE_CAP   = 3'd0;
  localparam logic [2:0] CFG_PERIODIC      = 3'd1;
  localparam logic [2:0] CFG_IN_RANGE      = 3'd2;
  localparam logic [2:0] CFG_DISCHARGED    = 3'd3;
  localparam logic [2:0] CFG_CHARGED       = 3'd4;
  localparam logic [2:0] CFG_HOLD_TICKS    = 3'd5;
  localparam logic [2:0] CFG_DISCH_TIMEOUT = 3'd6;
  localparam logic [2:0] CFG_CHARGE_LIMIT  = 3'd7;

  // Drive codes.
  localparam logic [2:0] DRV_HIZ      = 3'd0;
  localparam logic [2:0] DRV_330_HI   = 3'd1;
  localparam logic [2:0] DRV_10K_HI   = 3'd2;
  localparam logic [2:0] DRV_1M_HI    = 3'd3;
  localparam logic [2:0] DRV_330_LO   = 3'd4;
  localparam logic [2:0] DRV_1M_CHG   = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SCALE   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_R330    = 4'd1,
    PH_R10K    = 4'd2,
    PH_R1M     = 4'd3,
    PH_AVG     = 4'd4,
    PH_HOLD_R  = 4'd5,
    PH_OOR     = 4'd6,
    PH_DISCH   = 4'd7,
    PH_CHARGE  = 4'd8,
    PH_HOLD_C  = 4'd9,
    PH_TIMEOUT = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_STEP,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic mul;
    logic div_start;
    logic div_take;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [RANGE_W-1:0] range_ohms(input logic [1:0] sel);
    logic [RANGE_W-1:0] r;
    case (sel)
      2'd0:    r = 20'd330;
      2'd1:    r = 20'd10000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/armseq_div.sv]
// ----------------------------------------------------------------------------
// armseq_div
// Restoring divider, one quotient bit per cycle, for the ohms computation.
// ----------------------------------------------------------------------------
module armseq_div import armseq_pkg::*; #(
  parameter int DIVISOR_W = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [VALUE_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(VALUE_W - 1);

  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[VALUE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/armseq_ctrl.sv]
// ----------------------------------------------------------------------------
// armseq_ctrl
// Sequencer state machine: accepts a beat, steps the datapath, runs the
// ohms multiply and divide when a resistance result completes, and emits.
// ----------------------------------------------------------------------------
module armseq_ctrl import armseq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_WAIT:   if (in_tvalid) state_nxt = ST_STEP;
      ST_STEP:   state_nxt = sts.need_div ? ST_MUL : ST_EMIT;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_nxt = ST_WAIT;
      default:   state_nxt = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_WAIT: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_STEP:   cmd.step      = 1'b1;
      ST_MUL:    cmd.mul       = 1'b1;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_DIV:    cmd.div_take  = sts.div_done;
      ST_EMIT:   cmd.load_out  = sts.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/armseq_dp.sv]
// ----------------------------------------------------------------------------
// armseq_dp
// Datapath: configuration registers, measurement state, sample averaging,
// ohms multiply and divide, and the output register.
// ----------------------------------------------------------------------------
module armseq_dp import armseq_pkg::*; #(
  parameter int AVG_SAMPLES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  input  logic                 in_kind,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 cfg_wr,
  input  logic [2:0]           cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [3:0]           out_phase,
  output logic [2:0]           out_drive,
  output logic                 out_value_valid,
  output logic [VALUE_W-1:0]   out_measured_value,
  output logic                 out_value_is_cap,
  output logic [1:0]           out_error_code
);

  localparam int CNT_W  = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W  = $clog2(AVG_SAMPLES * 4095 + 1);
  localparam int DEN    = AVG_SAMPLES * FULL_COUNTS;
  localparam int DEN_W  = $clog2(DEN + 1);
  localparam int PROD_W = RANGE_W + SUM_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVG_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [DEN_W-1:0] DEN_C    = DEN_W'(DEN);

  // Configuration.
  logic                 meas_cap_r, periodic_r;
  logic [SAMPLE_W-1:0]  in_range_r, discharged_r, charged_r;
  logic [TICKS_W-1:0]   hold_ticks_r, disch_timeout_r, charge_limit_r;

  // Captured beat.
  logic                 kind_r;
  logic [SAMPLE_W-1:0]  sample_r;

  // Measurement state.
  phase_t               phase_r, phase_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic [TICKS_W-1:0]   charge_r, charge_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;

  // Result of the current beat.
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_cap_r, res_cap_nxt;
  logic [VALUE_W-1:0]   res_value_r;
  logic                 need_div;

  // Ohms arithmetic.
  logic [PROD_W-1:0]    prod_full;
  logic [VALUE_W-1:0]   prod_r;
  logic [DEN_W-1:0]     dsr_r;
  logic                 sat_r;
  logic                 div_done;
  logic [VALUE_W-1:0]   quotient;

  // Output register.
  logic                 out_valid_r;
  logic [3:0]           out_phase_r;
  logic [2:0]           out_drive_r;
  logic                 out_vv_r, out_cap_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [1:0]           out_err_r;
  logic [2:0]           drive_now;
  logic [1:0]           err_now;

  logic [HOLD_W-1:0]    hold_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_cap_r      <= 1'b0;
      periodic_r      <= 1'b0;
      in_range_r      <= RST_IN_RANGE_LIMIT;
      discharged_r    <= RST_DISCHARGED;
      charged_r       <= RST_CHARGED;
      hold_ticks_r    <= RST_HOLD_TICKS;
      disch_timeout_r <= RST_DISCH_TIMEOUT;
      charge_limit_r  <= RST_CHARGE_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MEASURE_CAP:   meas_cap_r      <= cfg_data[0];
        CFG_PERIODIC:      periodic_r      <= cfg_data[0];
        CFG_IN_RANGE:      in_range_r      <= cfg_data[SAMPLE_W-1:0];
        CFG_DISCHARGED:    discharged_r    <= cfg_data[SAMPLE_W-1:0];
        CFG_CHARGED:       charged_r       <= cfg_data[SAMPLE_W-1:0];
        CFG_HOLD_TICKS:    hold_ticks_r    <= cfg_data;
        CFG_DISCH_TIMEOUT: disch_timeout_r <= cfg_data;
        CFG_CHARGE_LIMIT:  charge_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      sample_r <= in_sample;
    end
  end

  assign hold_inc = (hold_r != HOLD_MAX) ? hold_r + 1'b1 : hold_r;

  // One beat of the measurement sequence.
  always_comb begin
    phase_nxt     = phase_r;
    hold_nxt      = hold_r;
    charge_nxt    = charge_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_valid_nxt = 1'b0;
    res_cap_nxt   = 1'b0;
    need_div      = 1'b0;
    if (kind_r) begin
      if (phase_r == PH_IDLE) begin
        hold_nxt  = '0;
        phase_nxt = meas_cap_r ? PH_DISCH : PH_R330;
      end else if (phase_r inside {[PH_HOLD_R:PH_TIMEOUT]}) begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_R330, PH_R10K, PH_R1M: begin
          if (sample_r <= in_range_r) begin
            sel_nxt   = 2'(phase_r - 4'd1);
            sum_nxt   = SUM_W'(sample_r);
            cnt_nxt   = CNT_ONE;
            phase_nxt = PH_AVG;
          end else if (phase_r == PH_R1M) begin
            phase_nxt = PH_OOR;
          end else begin
            phase_nxt = phase_t'(phase_r + 4'd1);
          end
        end
        PH_AVG: begin
          sum_nxt = sum_r + SUM_W'(sample_r);
          cnt_nxt = cnt_r + 1'b1;
        end
        PH_HOLD_R, PH_OOR, PH_HOLD_C: begin
          if (hold_r < {2'b00, hold_ticks_r}) begin
            hold_nxt = hold_inc;
          end else if (periodic_r) begin
            hold_nxt  = '0;
            phase_nxt = meas_cap_r ? PH_DISCH : PH_R330;
          end
        end
        PH_DISCH: begin
          if (sample_r <= discharged_r) begin
            phase_nxt  = PH_CHARGE;
            charge_nxt = '0;
          end else if (hold_r < {2'b00, disch_timeout_r}) begin
            hold_nxt = hold_inc;
          end else begin
            phase_nxt = PH_TIMEOUT;
          end
        end
        PH_CHARGE: begin
          if (sample_r >= charged_r) begin
            phase_nxt     = PH_HOLD_C;
            res_valid_nxt = 1'b1;
            res_cap_nxt   = 1'b1;
          end else if (charge_r < charge_limit_r) begin
            hold_nxt   = hold_inc;
            charge_nxt = charge_r + 1'b1;
          end else begin
            phase_nxt = PH_OOR;
          end
        end
        default: ;
      endcase
      // The average is complete once enough samples are summed.
      if (phase_nxt == PH_AVG && cnt_nxt >= CNT_FULL) begin
        need_div      = 1'b1;
        res_valid_nxt = 1'b1;
        phase_nxt     = PH_HOLD_R;
        hold_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hold_r   <= '0;
      charge_r <= '0;
      sel_r    <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
    end else if (cmd.step) begin
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      charge_r <= charge_nxt;
      sel_r    <= sel_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_valid_r <= res_valid_nxt;
      res_cap_r   <= res_cap_nxt;
      res_value_r <= res_cap_nxt ? VALUE_W'(charge_r) : '0;
    end else if (cmd.div_take) begin
      res_value_r <= sat_r ? MAX_VALUE : quotient;
    end
  end

  assign prod_full = range_ohms(sel_r) * sum_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= VALUE_W'(prod_full);
      dsr_r  <= DEN_C - DEN_W'(sum_r);
      sat_r  <= sum_r >= SUM_W'(DEN);
    end
  end

  armseq_div #(
    .DIVISOR_W(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dsr_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    case (phase_r)
      PH_R330:            drive_now = DRV_330_HI;
      PH_R10K:            drive_now = DRV_10K_HI;
      PH_R1M:             drive_now = DRV_1M_HI;
      PH_AVG, PH_HOLD_R: begin
        case (sel_r)
          2'd0:    drive_now = DRV_330_HI;
          2'd1:    drive_now = DRV_10K_HI;
          default: drive_now = DRV_1M_HI;
        endcase
      end
      PH_DISCH:           drive_now = DRV_330_LO;
      PH_CHARGE, PH_HOLD_C: drive_now = DRV_1M_CHG;
      default:            drive_now = DRV_HIZ;
    endcase
    case (phase_r)
      PH_OOR:     err_now = ERR_SCALE;
      PH_TIMEOUT: err_now = ERR_TIMEOUT;
      default:    err_now = ERR_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_phase_r <= phase_r;
      out_drive_r <= drive_now;
      out_vv_r    <= res_valid_r;
      out_cap_r   <= res_cap_r;
      out_value_r <= res_value_r;
      out_err_r   <= err_now;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid         = out_valid_r;
  assign out_phase          = out_phase_r;
  assign out_drive          = out_drive_r;
  assign out_value_valid    = out_vv_r;
  assign out_measured_value = out_value_r;
  assign out_value_is_cap   = out_cap_r;
  assign out_error_code     = out_err_r;

endmodule

[rtl/autorange_rc_meter_sequencer.sv]
// ----------------------------------------------------------------------------
// autorange_rc_meter_sequencer
// Autoranging ohmmeter and RC time-constant capacitance meter sequencer.
//
//   Channel | Direction | Payload
//   in_     | slave     | tuser[0] kind; tdata[11:0] adc_sample
//   out_    | master    | tdata phase, drive, valid, value, error; tuser is_cap
//   cfg_    | write     | cfg_index[2:0] register, cfg_data[13:0] value
//
// A beat that finishes a resistance average goes through step, multiply,
// divider start and the serial divider before emit; every other beat goes
// from step straight to emit. One beat is in work at a time; the next is
// accepted while the output register still holds the previous result.
// Reset is synchronous on rst_n and restores configuration and the idle phase.
// A stalled out_tready holds the result and delays the next beat's result.
// ----------------------------------------------------------------------------
module autorange_rc_meter_sequencer import armseq_pkg::*; #(
  parameter int AVG_SAMPLES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample, [15:12] zero
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] phase, [6:4] drive, [7] value_valid,
                                  // [47:8] measured_value, [49:48] error_code
  output logic        out_tuser,  // [0] value_is_capacitance
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  ctrl_cmd_t            cmd;
  dp_sts_t              sts;
  logic [3:0]           phase;
  logic [2:0]           drive;
  logic                 value_valid;
  logic [VALUE_W-1:0]   measured_value;
  logic [1:0]           error_code;

  assign cfg_ready = 1'b1;

  armseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  armseq_dp #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_tuser),
    .in_sample          (in_tdata[SAMPLE_W-1:0]),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_phase          (phase),
    .out_drive          (drive),
    .out_value_valid    (value_valid),
    .out_measured_value (measured_value),
    .out_value_is_cap   (out_tuser),
    .out_error_code     (error_code)
  );

  assign out_tdata = {6'b0, error_code, measured_value, value_valid, drive, phase};

endmodule

[verif/tb_autorange_rc_meter_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autorange_rc_meter_sequencer
// Self-checking bench for the autoranging R/C meter sequencer. A short table
// of hand-picked beats walks ranging, timeout, charge timing, the ignored
// beats and cancel; random sessions then rewrite every register, from the
// extremes to random settings, and push biased beats through. Each accepted
// input beat is run through a local copy of the meter, and every result beat
// is compared field by field with the oldest pending reading.
// ----------------------------------------------------------------------------
module tb_autorange_rc_meter_sequencer;
  import armseq_pkg::*;

  localparam int AVG_COUNT          = 32;
  localparam int SESSIONS           = 12;
  localparam int BEATS_PER_SESSION  = 140;
  localparam int QUIET_LIMIT        = 2000;
  localparam int MAX_PRINTED        = 100;
  // Sum of a full average at full scale; at or above it the value saturates.
  localparam logic [63:0] FULL_SUM  = 64'(AVG_COUNT) * 64'd4020;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;
  localparam logic TYPED       = 1'b1;
  localparam logic COMPUTED    = 1'b0;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         drive;
    logic               fresh;
    logic [VALUE_W-1:0] value;
    logic               is_cap;
    logic [1:0]         err;
  } meter_result_t;

  typedef struct packed {
    logic                measure_cap;
    logic                periodic;
    logic [SAMPLE_W-1:0] in_range_limit;
    logic [SAMPLE_W-1:0] discharged_level;
    logic [SAMPLE_W-1:0] charged_level;
    logic [TICKS_W-1:0]  hold_ticks;
    logic [TICKS_W-1:0]  discharge_timeout;
    logic [TICKS_W-1:0]  charge_limit;
  } meter_regs_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t             op;
    logic [2:0]          reg_idx;
    logic [13:0]         reg_val;
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    meter_result_t       want;
  } dir_row_t;

  localparam meter_result_t R_IDLE  = '{PH_IDLE, DRV_HIZ, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_330   = '{PH_R330, DRV_330_HI, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_10K   = '{PH_R10K, DRV_10K_HI, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_1M    = '{PH_R1M, DRV_1M_HI, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_OOR   = '{PH_OOR, DRV_HIZ, 1'b0, 40'd0, 1'b0, ERR_SCALE};
  localparam meter_result_t R_DISCH = '{PH_DISCH, DRV_330_LO, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_TMO   = '{PH_TIMEOUT, DRV_HIZ, 1'b0, 40'd0, 1'b0, ERR_TIMEOUT};
  localparam meter_result_t R_CHG   = '{PH_CHARGE, DRV_1M_CHG, 1'b0, 40'd0, 1'b0, ERR_NONE};
  localparam meter_result_t R_AVG   = '{PH_AVG, DRV_330_HI, 1'b0, 40'd0, 1'b0, ERR_NONE};

  localparam int DIR_ROWS_N = 27;
  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    TYPED,    R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd4095, TYPED,    R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_330},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd4095, TYPED,    R_330},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd3901, TYPED,    R_10K},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd4095, TYPED,    R_1M},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd4095, TYPED,    R_OOR},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    TYPED,    R_OOR},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_IDLE},
    '{ROW_CFG,  CFG_MEASURE_CAP, 14'd1, KIND_TICK,   12'd0,    COMPUTED, R_IDLE},
    '{ROW_CFG,  CFG_DISCH_TIMEOUT, 14'd1, KIND_TICK, 12'd0,    COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_DISCH},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd83,   TYPED,    R_DISCH},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd4095, TYPED,    R_TMO},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    TYPED,    R_TMO},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_DISCH},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd82,   TYPED,    R_CHG},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd2579, COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd2580, COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd4095, TYPED,    R_IDLE},
    '{ROW_CFG,  CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    TYPED,    R_330},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd0,    TYPED,    R_AVG},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_TICK,   12'd4095, COMPUTED, R_IDLE},
    '{ROW_BEAT, CFG_MEASURE_CAP, 14'd0, KIND_BUTTON, 12'd0,    COMPUTED, R_IDLE}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // [11:0] adc_sample
  logic        in_tuser   = 1'b0;  // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [55:0] out_tdata;  // [3:0] phase, [6:4] drive, [7] value_valid,
                           // [47:8] measured_value, [49:48] error_code
  logic        out_tuser;  // [0] value_is_capacitance
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [13:0] cfg_data   = '0;

  // Local copy of the meter.
  meter_regs_t          regs;
  phase_t               cur_phase;
  logic [HOLD_W-1:0]    hold_count;
  logic [TICKS_W-1:0]   charge_count;
  logic [1:0]           range_sel;
  logic [5:0]           sample_count;
  logic [16:0]          sample_total;

  meter_result_t pending_readings[$];
  int            errors       = 0;
  int            quiet_cycles = 0;
  bit            idle_on      = 1'b1;
  int            avg_style    = 0;

  autorange_rc_meter_sequencer #(
    .AVG_SAMPLES (AVG_COUNT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [39:0] got,
                             input logic [39:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic start_measure();
    hold_count = '0;
    cur_phase  = regs.measure_cap ? PH_DISCH : PH_R330;
  endtask

  task automatic bump_hold();
    if (hold_count != HOLD_MAX) hold_count++;
  endtask

  // Steps the local meter by one accepted beat and queues the reading it gives.
  task automatic advance_meter(input logic kind, input logic [SAMPLE_W-1:0] s);
    meter_result_t r;
    logic [63:0]   rohm;
    logic [63:0]   quot;
    r = R_IDLE;
    if (kind == KIND_BUTTON) begin
      if (cur_phase == PH_IDLE) start_measure();
      else if (cur_phase >= PH_HOLD_R) cur_phase = PH_IDLE;
    end else begin
      case (cur_phase)
        PH_R330, PH_R10K, PH_R1M: begin
          if (s <= regs.in_range_limit) begin
            // The deciding sample also opens the average.
            range_sel    = 2'(cur_phase - PH_R330);
            sample_total = 17'(s);
            sample_count = 6'd1;
            cur_phase    = PH_AVG;
          end else begin
            cur_phase = (cur_phase == PH_R1M) ? PH_OOR : phase_t'(cur_phase + 4'd1);
          end
        end
        PH_AVG: begin
          sample_total = sample_total + 17'(s);
          sample_count++;
        end
        PH_HOLD_R, PH_OOR, PH_HOLD_C: begin
          if (hold_count < 16'(regs.hold_ticks)) bump_hold();
          else if (regs.periodic) start_measure();
        end
        PH_DISCH: begin
          if (s <= regs.discharged_level) begin
            cur_phase    = PH_CHARGE;
            charge_count = '0;
          end else if (hold_count < 16'(regs.discharge_timeout)) begin
            bump_hold();
          end else begin
            cur_phase = PH_TIMEOUT;
          end
        end
        PH_CHARGE: begin
          if (s >= regs.charged_level) begin
            cur_phase = PH_HOLD_C;
            r.fresh   = 1'b1;
            r.is_cap  = 1'b1;
            r.value   = 40'(charge_count);
          end else if (charge_count < regs.charge_limit) begin
            bump_hold();
            charge_count++;
          end else begin
            cur_phase = PH_OOR;
          end
        end
        default: ;
      endcase
      if (cur_phase == PH_AVG && sample_count >= 6'(AVG_COUNT)) begin
        case (range_sel)
          2'd0:    rohm = 64'd330;
          2'd1:    rohm = 64'd10000;
          default: rohm = 64'd1000000;
        endcase
        if (64'(sample_total) >= FULL_SUM) begin
          r.value = MAX_VALUE;
        end else begin
          quot    = (rohm * 64'(sample_total)) / (FULL_SUM - 64'(sample_total));
          r.value = (quot > 64'(MAX_VALUE)) ? MAX_VALUE : quot[VALUE_W-1:0];
        end
        r.fresh    = 1'b1;
        cur_phase  = PH_HOLD_R;
        hold_count = '0;
      end
    end
    case (cur_phase)
      PH_R330, PH_R10K, PH_R1M: r.drive = 3'(cur_phase);
      PH_AVG, PH_HOLD_R:        r.drive = (range_sel >= 2'd2) ? DRV_1M_HI : 3'(range_sel + 2'd1);
      PH_DISCH:                 r.drive = DRV_330_LO;
      PH_CHARGE, PH_HOLD_C:     r.drive = DRV_1M_CHG;
      default:                  r.drive = DRV_HIZ;
    endcase
    r.err   = (cur_phase == PH_OOR) ? ERR_SCALE :
              (cur_phase == PH_TIMEOUT) ? ERR_TIMEOUT : ERR_NONE;
    r.phase = cur_phase;
    pending_readings.push_back(r);
  endtask

  task automatic send_beat(input logic kind, input logic [SAMPLE_W-1:0] s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_meter(kind, s);
  endtask

  // Lets every pending reading come back before registers are touched.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MEASURE_CAP:   regs.measure_cap       = val[0];
      CFG_PERIODIC:      regs.periodic          = val[0];
      CFG_IN_RANGE:      regs.in_range_limit    = val[11:0];
      CFG_DISCHARGED:    regs.discharged_level  = val[11:0];
      CFG_CHARGED:       regs.charged_level     = val[11:0];
      CFG_HOLD_TICKS:    regs.hold_ticks        = val;
      CFG_DISCH_TIMEOUT: regs.discharge_timeout = val;
      CFG_CHARGE_LIMIT:  regs.charge_limit      = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] sample_le(input logic [SAMPLE_W-1:0] t);
    return 12'($urandom_range(0, int'(t)));
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_gt(input logic [SAMPLE_W-1:0] t);
    return (t == 12'hFFF) ? 12'hFFF : 12'($urandom_range(int'(t) + 1, 4095));
  endfunction

  // Picks the next beat from the meter's current phase, so that most runs get
  // through ranging, averaging and charge timing; a slice stays pure noise.
  task automatic pick_beat(output logic kind, output logic [SAMPLE_W-1:0] s);
    int roll;
    roll = $urandom_range(0, 99);
    kind = KIND_TICK;
    s    = 12'($urandom);
    if (roll < 8) begin
      kind = 1'($urandom);
    end else begin
      case (cur_phase)
        PH_IDLE: begin
          kind      = (roll < 90) ? KIND_BUTTON : KIND_TICK;
          avg_style = $urandom_range(0, 3);
        end
        PH_R330, PH_R10K, PH_R1M: begin
          if (roll >= 55) s = sample_gt(regs.in_range_limit);
          else if (avg_style == 1 && regs.in_range_limit >= 12'd4020)
            s = 12'($urandom_range(4020, int'(regs.in_range_limit)));
          else s = sample_le(regs.in_range_limit);
        end
        PH_AVG: begin
          if (roll > 96) kind = KIND_BUTTON;
          case (avg_style)
            1: s = 12'($urandom_range(4020, 4095));
            2: s = 12'($urandom_range(0, 15));
            3: s = 12'($urandom_range(1500, 2600));
            default: ;
          endcase
        end
        PH_DISCH: begin
          if (roll > 96) kind = KIND_BUTTON;
          else if (roll < 30) s = sample_le(regs.discharged_level);
          else s = sample_gt(regs.discharged_level);
        end
        PH_CHARGE: begin
          if (roll > 96) kind = KIND_BUTTON;
          else if (roll < 25) s = 12'($urandom_range(int'(regs.charged_level), 4095));
          else if (regs.charged_level == 12'd0) s = 12'd0;
          else s = 12'($urandom_range(0, int'(regs.charged_level) - 1));
        end
        PH_TIMEOUT: kind = (roll < 70) ? KIND_BUTTON : KIND_TICK;
        default: begin
          // A single-shot hold only ends on a button.
          if (roll > 95 || (!regs.periodic && hold_count >= 16'(regs.hold_ticks) && roll > 60))
            kind = KIND_BUTTON;
        end
      endcase
    end
  endtask

  task automatic drain_to_idle();
    while (cur_phase != PH_IDLE) begin
      if (cur_phase >= PH_R330 && cur_phase <= PH_AVG) send_beat(KIND_TICK, 12'($urandom));
      else send_beat(KIND_BUTTON, 12'($urandom));
    end
  endtask

  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    meter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result beat with no reading pending");
      end else begin
        want = pending_readings.pop_front();
        check_field("phase", 40'(out_tdata[3:0]), 40'(want.phase));
        check_field("drive", 40'(out_tdata[6:4]), 40'(want.drive));
        check_field("value_valid", 40'(out_tdata[7]), 40'(want.fresh));
        check_field("measured_value", out_tdata[47:8], want.value);
        check_field("error_code", 40'(out_tdata[49:48]), 40'(want.err));
        check_field("value_is_capacitance", 40'(out_tuser), 40'(want.is_cap));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int            i;
    int            sess;
    int            n;
    dir_row_t      row;
    logic          k;
    logic [11:0]   smp;
    logic          all_max;
    regs.measure_cap       = 1'b0;
    regs.periodic          = 1'b0;
    regs.in_range_limit    = RST_IN_RANGE_LIMIT;
    regs.discharged_level  = RST_DISCHARGED;
    regs.charged_level     = RST_CHARGED;
    regs.hold_ticks        = RST_HOLD_TICKS;
    regs.discharge_timeout = RST_DISCH_TIMEOUT;
    regs.charge_limit      = RST_CHARGE_LIMIT;
    cur_phase    = PH_IDLE;
    hold_count   = '0;
    charge_count = '0;
    range_sel    = '0;
    sample_count = '0;
    sample_total = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.op == ROW_CFG) begin
        wait_quiet();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_beat(row.kind, row.sample);
        // A hand-written reading replaces the computed one.
        if (row.typed) pending_readings[pending_readings.size() - 1] = row.want;
      end
    end
    drain_to_idle();

    for (sess = 0; sess < SESSIONS; sess++) begin
      wait_quiet();
      if (sess >= SESSIONS - 2) idle_on = 1'b0;
      if (sess < 4) begin
        // Two sessions with every threshold and count at its top, two at zero.
        all_max = (sess < 2);
        write_reg(CFG_MEASURE_CAP, 14'(sess % 2));
        write_reg(CFG_PERIODIC, 14'(sess / 2));
        write_reg(CFG_IN_RANGE, all_max ? 14'hFFF : 14'd0);
        write_reg(CFG_DISCHARGED, all_max ? 14'hFFF : 14'd0);
        write_reg(CFG_CHARGED, all_max ? 14'hFFF : 14'd0);
        write_reg(CFG_HOLD_TICKS, all_max ? 14'h3FFF : 14'd0);
        write_reg(CFG_DISCH_TIMEOUT, all_max ? 14'h3FFF : 14'd0);
        write_reg(CFG_CHARGE_LIMIT, all_max ? 14'h3FFF : 14'd0);
      end else begin
        write_reg(CFG_MEASURE_CAP, 14'($urandom_range(0, 1)));
        write_reg(CFG_PERIODIC, 14'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_IN_RANGE, 14'd3900);
          1:       write_reg(CFG_IN_RANGE, 14'd4095);
          2:       write_reg(CFG_IN_RANGE, 14'($urandom_range(0, 400)));
          default: write_reg(CFG_IN_RANGE, 14'($urandom_range(0, 4095)));
        endcase
        write_reg(CFG_DISCHARGED, 14'($urandom_range(0, 600)));
        write_reg(CFG_CHARGED, 14'($urandom_range(1000, 4095)));
        write_reg(CFG_HOLD_TICKS, 14'($urandom_range(0, 15)));
        write_reg(CFG_DISCH_TIMEOUT, 14'($urandom_range(0, 40)));
        write_reg(CFG_CHARGE_LIMIT, 14'($urandom_range(0, 60)));
      end
      for (n = 0; n < BEATS_PER_SESSION; n++) begin
        pick_beat(k, smp);
        send_beat(k, smp);
      end
      drain_to_idle();
    end

    wait_quiet();
    repeat (60) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
